FILE: hw/rtl/mmwg_pkg.sv
// mmwg_pkg: shared types and constants of the multi-mode waveform generator.
// No dependencies; imported by every module of the block.

package mmwg_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX   = 3'd5;

    // waveform mode codes
    localparam logic [2:0] MODE_SINE     = 3'd0;
    localparam logic [2:0] MODE_SQUARE   = 3'd1;
    localparam logic [2:0] MODE_TRIANGLE = 3'd2;
    localparam logic [2:0] MODE_SAWTOOTH = 3'd3;
    localparam logic [2:0] MODE_IMPULSE  = 3'd4;
    localparam logic [2:0] MODE_DECAY    = 3'd5;

    typedef struct packed {
        logic [2:0]  wave_mode;
        logic [14:0] amplitude;
        logic [31:0] phase_step;
        logic [31:0] phase_offset;
        logic [15:0] decay_factor;
        logic [31:0] last_index;
    } cfg_t;

    // 1.0 in Q1.16
    localparam logic [16:0] LEVEL_ONE = 17'd65536;
    // pi/2 in Q30
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam int TAYLOR_TERMS = 7;

    // input queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Division of Taylor term k by d = (2k)(2k+1): multiply by
    // ceil(2^(32+l)/d) and shift right by 32+l, with 2^l >= d.
    // Exact floor for any 32-bit dividend.
    function automatic logic [32:0] taylor_recip(input logic [2:0] k);
        logic [32:0] m;
        unique case (k)
            3'd1:    m = 33'd5726623062;   // d = 6
            3'd2:    m = 33'd6871947674;   // d = 20
            3'd3:    m = 33'd6544712071;   // d = 42
            3'd4:    m = 33'd7635497416;   // d = 72
            3'd5:    m = 33'd4997780127;   // d = 110
            3'd6:    m = 33'd7048151461;   // d = 156
            3'd7:    m = 33'd5235769657;   // d = 210
            default: m = 33'd0;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] taylor_shift(input logic [2:0] k);
        logic [3:0] l;
        unique case (k)
            3'd1:    l = 4'd3;
            3'd2:    l = 4'd5;
            3'd3:    l = 4'd6;
            3'd4:    l = 4'd7;
            3'd5:    l = 4'd7;
            3'd6:    l = 4'd8;
            3'd7:    l = 4'd8;
            default: l = 4'd0;
        endcase
        return l;
    endfunction

endpackage

FILE: hw/rtl/mmwg_front.sv
// mmwg_front: input handshake and short item queue ahead of the sample engine.
// Depends on mmwg_pkg.

module mmwg_front
    import mmwg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic enable,
    input  logic in_valid,
    output logic in_ready,
    input  logic in_restart,
    output logic q_valid,
    output logic q_restart,
    input  logic q_pop
);

    localparam logic [QPTR_W:0] Q_FULL = (QPTR_W+1)'(QUEUE_DEPTH);

    logic              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push;
    logic              pop;

    assign in_ready  = enable && (count_reg != Q_FULL);
    assign push      = in_valid && in_ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_restart = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_restart;
        end
    end

endmodule

FILE: hw/rtl/mmwg_sine_rom.sv
// mmwg_sine_rom: quarter-wave sine table, built after reset by a Taylor-series
// engine (a shared multiplier, divisions by reciprocal). Depends on mmwg_pkg.

module mmwg_sine_rom
    import mmwg_pkg::*;
#(
    parameter int TABLE_ADDR_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    output logic                     ready,
    input  logic                     rd_en,
    input  logic [TABLE_ADDR_BITS:0] rd_addr,
    output logic [16:0]              rd_data
);

    localparam int DEPTH     = (1 << TABLE_ADDR_BITS) + 1;
    localparam logic [TABLE_ADDR_BITS:0] LAST_ENTRY = {1'b1, {TABLE_ADDR_BITS{1'b0}}};
    localparam logic [2:0] LAST_TERM = 3'(TAYLOR_TERMS);

    // Per entry: X, X2, then MUL/DIV/ACC per term, then WR
    typedef enum logic [6:0] {
        FS_X    = 7'b0000001,
        FS_X2   = 7'b0000010,
        FS_MUL  = 7'b0000100,
        FS_DIV  = 7'b0001000,
        FS_ACC  = 7'b0010000,
        FS_WR   = 7'b0100000,
        FS_DONE = 7'b1000000
    } fill_state_t;

    fill_state_t state_reg, state_next;
    logic [TABLE_ADDR_BITS:0] i_reg, i_next;
    logic [2:0]  k_reg, k_next;
    logic [30:0] x_reg, x_next;
    logic [31:0] x2_reg, x2_next;
    logic [31:0] term_reg, term_next;
    logic [33:0] sum_reg, sum_next;
    logic [31:0] dq_reg, dq_next;

    logic [TABLE_ADDR_BITS+31:0] x_prod;
    logic [61:0] sq_prod;
    logic [31:0] mul_a;
    logic [32:0] mul_b;
    logic [64:0] mul_p;
    logic [64:0] div_q;
    logic [32:0] recip;
    logic [3:0]  rsh;
    logic [34:0] sum_round;
    logic [20:0] entry_wide;
    logic [16:0] entry;
    logic        wr_en;

    logic [16:0] mem [DEPTH];
    logic [16:0] rd_q;

    assign ready   = (state_reg == FS_DONE);
    assign rd_data = rd_q;
    assign wr_en   = (state_reg == FS_WR);

    assign x_prod     = (TABLE_ADDR_BITS+32)'(i_reg) * (TABLE_ADDR_BITS+32)'(HALF_PI_Q30);
    assign sq_prod    = 62'(x_reg) * 62'(x_reg);
    // shared multiplier: term * x2 in FS_MUL, dividend * reciprocal in FS_DIV
    assign recip      = taylor_recip(k_reg);
    assign rsh        = taylor_shift(k_reg);
    assign mul_a      = (state_reg == FS_DIV) ? dq_reg : term_reg;
    assign mul_b      = (state_reg == FS_DIV) ? recip : {1'b0, x2_reg};
    assign mul_p      = 65'(mul_a) * 65'(mul_b);
    assign div_q      = mul_p >> (7'd32 + 7'(rsh));
    assign sum_round  = 35'(sum_reg) + 35'd8192;
    assign entry_wide = sum_round[34:14];
    assign entry      = (entry_wide > 21'(LEVEL_ONE)) ? LEVEL_ONE : entry_wide[16:0];

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        dq_next    = dq_reg;
        unique case (state_reg)
            FS_X:
            begin
                x_next     = x_prod[TABLE_ADDR_BITS+30:TABLE_ADDR_BITS];
                state_next = FS_X2;
            end
            FS_X2:
            begin
                x2_next    = sq_prod[61:30];
                term_next  = 32'(x_reg);
                sum_next   = 34'(x_reg);
                k_next     = 3'd1;
                state_next = FS_MUL;
            end
            FS_MUL:
            begin
                // x <= pi/2 keeps every dividend below 2^32
                dq_next    = mul_p[61:30];
                state_next = FS_DIV;
            end
            FS_DIV:
            begin
                dq_next    = div_q[31:0];
                state_next = FS_ACC;
            end
            FS_ACC:
            begin
                term_next = dq_reg;
                sum_next  = k_reg[0] ? sum_reg - 34'(dq_reg)
                                     : sum_reg + 34'(dq_reg);
                if (k_reg == LAST_TERM)
                begin
                    state_next = FS_WR;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = FS_MUL;
                end
            end
            FS_WR:
            begin
                if (i_reg == LAST_ENTRY)
                begin
                    state_next = FS_DONE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = FS_X;
                end
            end
            FS_DONE:
            begin
                state_next = FS_DONE;
            end
            default:
            begin
                state_next = FS_X;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_X;
            i_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        dq_reg   <= dq_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[i_reg] <= entry;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/mmwg_back.sv
// mmwg_back: run state (index, phase, decay level) and the three-stage sample
// pipeline ending in the output register. Depends on mmwg_pkg (ROM via ports).

module mmwg_back
    import mmwg_pkg::*;
#(
    parameter int TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS,
    parameter int PHASE_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         q_valid,
    input  logic                         q_restart,
    output logic                         q_pop,
    output logic                         rd_en,
    output logic [TABLE_ADDR_BITS:0]     rd_addr,
    input  logic [16:0]                  rd_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_value,
    output logic [31:0]                  sample_number,
    output logic                         last_sample,
    output logic                         active
);

    localparam int AMAX_I = (SAMPLE_BITS - 1 >= 15) ? 32767 : (1 << (SAMPLE_BITS - 1)) - 1;
    localparam logic [14:0] AMP_CAP = AMAX_I[14:0];
    localparam logic [PHASE_BITS-1:0] HALF_STEP = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [TABLE_ADDR_BITS:0] QUARTER = {1'b1, {TABLE_ADDR_BITS{1'b0}}};
    localparam int VW = 19;

    // run state
    logic [31:0]           idx_reg, idx_next;
    logic [PHASE_BITS-1:0] acc_reg, acc_next;
    logic [16:0]           lvl_reg, lvl_next;
    logic                  running_reg, running_next;

    logic adv;
    logic pop;
    logic run_eff;
    logic is_last;
    logic [31:0]           idx_eff;
    logic [PHASE_BITS-1:0] acc_eff;
    logic [16:0]           lvl_eff;
    logic [PHASE_BITS+31:0] step_wide, off_wide;
    logic [PHASE_BITS-1:0] step_al, off_al, eff_step, phase;
    logic [32:0]           lvl_round;
    logic [TABLE_ADDR_BITS-1:0] tidx;
    logic [15:0]           frac;
    logic [14:0]           amp_c;

    // stage 1
    logic        s1_valid_reg;
    logic        s1_active_reg, s1_last_reg, s1_neg_reg, s1_imp_reg;
    logic [31:0] s1_n_reg;
    logic [2:0]  s1_mode_reg;
    logic [14:0] s1_amp_reg;
    logic [15:0] s1_f_reg;
    logic [16:0] s1_lvl_reg;
    logic [16:0] mop;

    // stage 2
    logic        s2_valid_reg;
    logic        s2_active_reg, s2_last_reg, s2_neg_reg, s2_imp_reg, s2_tnz_reg, s2_hi_reg;
    logic [31:0] s2_n_reg;
    logic [2:0]  s2_mode_reg;
    logic [14:0] s2_amp_reg;
    logic [31:0] s2_prod_reg;

    logic [33:0] scaled, rnd;
    logic signed [VW-1:0] r_s, amp_s, val;

    // output register
    logic                         out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic [31:0]                  number_reg;
    logic                         last_reg;
    logic                         active_reg;

    assign adv   = !out_valid_reg || out_ready;
    assign pop   = adv && q_valid;
    assign q_pop = pop;
    assign rd_en = adv;

    assign out_valid     = out_valid_reg;
    assign sample_value  = value_reg;
    assign sample_number = number_reg;
    assign last_sample   = last_reg;
    assign active        = active_reg;

    // front of the pipeline: restart, next state and table address
    always_comb
    begin
        step_wide = {cfg.phase_step, {PHASE_BITS{1'b0}}};
        off_wide  = {cfg.phase_offset, {PHASE_BITS{1'b0}}};
        step_al   = step_wide[PHASE_BITS+31 -: PHASE_BITS];
        off_al    = off_wide[PHASE_BITS+31 -: PHASE_BITS];
        eff_step  = (step_al > HALF_STEP) ? HALF_STEP : step_al;

        run_eff = q_restart || running_reg;
        idx_eff = q_restart ? '0 : idx_reg;
        acc_eff = q_restart ? '0 : acc_reg;
        lvl_eff = q_restart ? LEVEL_ONE : lvl_reg;
        is_last = (idx_eff == cfg.last_index);

        lvl_round = 33'(lvl_eff) * 33'(cfg.decay_factor) + 33'd32768;

        phase   = acc_eff + off_al;
        tidx    = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
        rd_addr = phase[PHASE_BITS-2] ? QUARTER - {1'b0, tidx} : {1'b0, tidx};
        frac    = acc_eff[PHASE_BITS-1 -: 16];
        amp_c   = (cfg.amplitude > AMP_CAP) ? AMP_CAP : cfg.amplitude;

        idx_next     = idx_reg;
        acc_next     = acc_reg;
        lvl_next     = lvl_reg;
        running_next = running_reg;
        if (pop && run_eff)
        begin
            running_next = !is_last;
            if (is_last)
            begin
                idx_next = idx_eff;
                acc_next = acc_eff;
                lvl_next = lvl_eff;
            end
            else
            begin
                idx_next = idx_eff + 32'd1;
                acc_next = acc_eff + eff_step;
                lvl_next = lvl_round[32:16];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            acc_reg       <= '0;
            lvl_reg       <= LEVEL_ONE;
            running_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            acc_reg     <= acc_next;
            lvl_reg     <= lvl_next;
            running_reg <= running_next;
            if (adv)
            begin
                s1_valid_reg  <= pop;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage 1 capture
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_active_reg <= run_eff;
            s1_last_reg   <= run_eff && is_last;
            s1_n_reg      <= idx_eff;
            s1_mode_reg   <= cfg.wave_mode;
            s1_amp_reg    <= amp_c;
            s1_neg_reg    <= phase[PHASE_BITS-1];
            s1_f_reg      <= frac;
            s1_lvl_reg    <= lvl_eff;
            s1_imp_reg    <= (idx_eff == '0) || (acc_eff < eff_step);
        end
    end

    // stage 2: one multiply, amplitude times the mode's operand
    always_comb
    begin
        case (s1_mode_reg) inside
            MODE_SINE, MODE_SQUARE: mop = rd_data;
            MODE_TRIANGLE:          mop = {2'b00, s1_f_reg[14:0]};
            MODE_SAWTOOTH:          mop = {1'b0, s1_f_reg};
            MODE_DECAY:             mop = s1_lvl_reg;
            default:                mop = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_prod_reg   <= 32'(s1_amp_reg) * 32'(mop);
            s2_tnz_reg    <= (rd_data != '0);
            s2_hi_reg     <= s1_f_reg[15];
            s2_active_reg <= s1_active_reg;
            s2_last_reg   <= s1_last_reg;
            s2_n_reg      <= s1_n_reg;
            s2_mode_reg   <= s1_mode_reg;
            s2_amp_reg    <= s1_amp_reg;
            s2_neg_reg    <= s1_neg_reg;
            s2_imp_reg    <= s1_imp_reg;
        end
    end

    // stage 3: scale, round half up, offset and sign
    always_comb
    begin
        case (s2_mode_reg)
            MODE_TRIANGLE: scaled = {s2_prod_reg, 2'b00};
            MODE_SAWTOOTH: scaled = {1'b0, s2_prod_reg, 1'b0};
            default:       scaled = {2'b00, s2_prod_reg};
        endcase
        rnd   = scaled + 34'd32768;
        r_s   = {1'b0, rnd[33:16]};
        amp_s = {4'b0000, s2_amp_reg};
        case (s2_mode_reg)
            MODE_SINE:     val = s2_neg_reg ? -r_s : r_s;
            MODE_SQUARE:   val = (s2_neg_reg && s2_tnz_reg) ? -amp_s : amp_s;
            MODE_TRIANGLE: val = s2_hi_reg ? amp_s - r_s : r_s - amp_s;
            MODE_SAWTOOTH: val = r_s - amp_s;
            MODE_IMPULSE:  val = s2_imp_reg ? amp_s : '0;
            MODE_DECAY:    val = r_s;
            default:       val = '0;
        endcase
        if (!s2_active_reg)
        begin
            val = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg  <= SAMPLE_BITS'(val);
            number_reg <= s2_n_reg;
            last_reg   <= s2_last_reg;
            active_reg <= s2_active_reg;
        end
    end

endmodule

FILE: hw/rtl/multi_mode_waveform_generator.sv
// multi_mode_waveform_generator: DDS function generator, top level.
// Items pass the input queue, stage 1, stage 2 and the output register; one item per
// cycle while m_tready keeps the output moving. The pace is set by the back pipeline
// (table read, multiply, round/sign stages). Reset is asynchronous, active low; after it
// the sine table is built, and s_tready stays low until the build is done.
// Depends on mmwg_pkg, mmwg_front, mmwg_sine_rom and mmwg_back.

module multi_mode_waveform_generator
    import mmwg_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16,
    parameter int PHASE_BITS      = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]            cfg_data,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [0] restart, [7:1] zero
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [((SAMPLE_BITS+32+7)/8)*8-1:0] m_tdata, // sample_value, sample_number, pad
    output logic                   m_tlast,   // last_sample
    output logic                   m_tuser    // active
);

    localparam int OUT_W = ((SAMPLE_BITS + 32 + 7) / 8) * 8;

    cfg_t cfg_reg, cfg_next;

    logic table_ready;
    logic q_valid;
    logic q_restart;
    logic q_pop;
    logic rd_en;
    logic [TABLE_ADDR_BITS:0] rd_addr;
    logic [16:0] rd_data;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [31:0] sample_number;

    // Register file; unknown indexes drop. The user must write only while no item is
    // in flight, so the pipeline sees a stable setting per sample; unchecked by the block.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAVE_MODE:    cfg_next.wave_mode    = cfg_data[2:0];
                REG_AMPLITUDE:    cfg_next.amplitude    = cfg_data[14:0];
                REG_PHASE_STEP:   cfg_next.phase_step   = cfg_data;
                REG_PHASE_OFFSET: cfg_next.phase_offset = cfg_data;
                REG_DECAY_FACTOR: cfg_next.decay_factor = cfg_data[15:0];
                REG_LAST_INDEX:   cfg_next.last_index   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: takes items once the table is built and queues them, so the
    // input side keeps flowing while a result waits at the output, until the queue fills.
    mmwg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (table_ready),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_restart (s_tdata[0]),
        .q_valid    (q_valid),
        .q_restart  (q_restart),
        .q_pop      (q_pop)
    );

    // Quarter-wave sine table with its build engine.
    mmwg_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .clk     (clk),
        .rst_n   (rst_n),
        .ready   (table_ready),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Back: phase accumulator, index and decay state, then the sample pipeline.
    mmwg_back #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_restart     (q_restart),
        .q_pop         (q_pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .sample_value  (sample_value),
        .sample_number (sample_number),
        .last_sample   (m_tlast),
        .active        (m_tuser)
    );

    // sample_value in the low bits, then sample_number, zero padded to bytes
    assign m_tdata = OUT_W'({sample_number, sample_value});

endmodule
